// ===== src/qida_pkg.sv =====
// Shared types, constants and helpers for the queue id allocator.
// Used by qida_bank, qida_exec and queue_id_allocator_with_refcount.
`default_nettype none

package qida_pkg;

	localparam int NUM_QUEUES      = 32;
	localparam int NUM_DEVICES_DEF = 1;
	localparam int QUEUE_DEPTH     = 1024;
	localparam int SLOT_BYTES      = 64;

	localparam int ID_W   = 5;
	localparam int TOP_W  = 6;
	localparam int CNT_W  = 8;
	localparam int DEV_W  = 2;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 4;
	localparam int ADDR_W = 48;

	localparam logic [ADDR_W-1:0] QUEUE_STRIDE = ADDR_W'(QUEUE_DEPTH * SLOT_BYTES);
	localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [TOP_W-1:0]  top_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 3'd0,
		CMD_FREE  = 3'd1,
		CMD_ADD   = 3'd2,
		CMD_DROP  = 3'd3,
		CMD_QUERY = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK          = 4'd0,
		ST_NONE_FREE   = 4'd1,
		ST_BAD_ID      = 4'd2,
		ST_REFERENCED  = 4'd3,
		ST_NOT_ALLOC   = 4'd4,
		ST_OVERFLOW    = 4'd5,
		ST_UNDERFLOW   = 4'd6,
		ST_BAD_DEVICE  = 4'd7,
		ST_BAD_COMMAND = 4'd8
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [DEV_W-1:0] device_id;
		logic [ID_W-1:0]  queue_id;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   result_id;
		logic [CNT_W-1:0]  reference_count;
		logic [TOP_W-1:0]  free_count;
		logic [ADDR_W-1:0] queue_address;
	} out_t;

	// state seen by the command logic for one device
	typedef struct packed {
		top_t top;
		id_t  pop_id;
		cnt_t cnt;
		logic alloc;
	} rd_t;

	// state change requested for one device
	typedef struct packed {
		logic pop;
		logic push;
		id_t  id;
		logic cnt_we;
		cnt_t cnt;
		logic flag_we;
		logic flag;
	} upd_t;

	function automatic addr_t addr_of(input addr_t base, input id_t id);
		addr_t off;
		off = ADDR_W'(id) * QUEUE_STRIDE;
		return base + off;
	endfunction

endpackage

`default_nettype wire

// ===== src/queue_id_allocator_with_refcount.sv =====
// Top level of the queue id allocator: input register, per-device banks, result register.
// Depends on qida_pkg, qida_bank and qida_exec.
`default_nettype none

// Submission-queue id allocator. Each device has a LIFO stack of free ids (ids come
// out in ascending order after reset, a freed id is handed out next) and an 8-bit
// stream reference count per id; every command gives exactly one result. The block
// takes one command per cycle unless out_ready holds back the result register, and
// returns its result through the input register, then the result register, with the
// read-modify-write of the addressed device's stack and count in between. The
// region base register is written over the cfg channel, which is always ready; write
// it only while no command is in flight. No clearing pass: state is ready at reset.
module queue_id_allocator_with_refcount
	import qida_pkg::*;
#(
	parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire in_t   in_data,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_t       out_data,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire addr_t cfg_data
);

	logic  valid_s1;
	in_t   item_s1;
	logic  valid_s2;
	out_t  res_s2;
	addr_t base_q;
	logic  adv;
	rd_t   rd;
	rd_t   bank_rd [NUM_DEVICES];
	upd_t  bank_upd [NUM_DEVICES];
	upd_t  upd;
	out_t  res;

	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	for (genvar g = 0; g < NUM_DEVICES; g++) begin : g_bank
		assign bank_upd[g] = (adv && item_s1.device_id == DEV_W'(g)) ? upd : '0;

		qida_bank u_bank (
			.clk    (clk),
			.arst_n (arst_n),
			.rd_qid (item_s1.queue_id),
			.upd    (bank_upd[g]),
			.rd     (bank_rd[g])
		);
	end

	always_comb begin
		rd = '0;
		for (int g = 0; g < NUM_DEVICES; g++) begin
			if (item_s1.device_id == DEV_W'(g)) begin
				rd = bank_rd[g];
			end
		end
	end

	qida_exec #(
		.NUM_DEVICES (NUM_DEVICES)
	) u_exec (
		.item (item_s1),
		.base (base_q),
		.rd   (rd),
		.res  (res),
		.upd  (upd)
	);

endmodule

`default_nettype wire

// ===== src/qida_bank.sv =====
// One device's allocator state: LIFO free stack, stack top, refcounts, alloc flags.
// Depends on qida_pkg.
`default_nettype none

module qida_bank
	import qida_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire id_t  rd_qid,
	input  wire upd_t upd,
	output rd_t       rd
);

	id_t  stack_q [NUM_QUEUES];
	cnt_t cnt_q [NUM_QUEUES];
	logic alloc_q [NUM_QUEUES];
	top_t top_q;
	top_t top_m1;

	assign top_m1    = top_q - TOP_W'(1);
	assign rd.top    = top_q;
	assign rd.pop_id = stack_q[top_m1[ID_W-1:0]];
	assign rd.cnt    = cnt_q[rd_qid];
	assign rd.alloc  = alloc_q[rd_qid];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_QUEUES; j++) begin
				stack_q[j] <= ID_W'(NUM_QUEUES - 1 - j);
				cnt_q[j]   <= '0;
				alloc_q[j] <= 1'b0;
			end
			top_q <= TOP_W'(NUM_QUEUES);
		end else begin
			if (upd.pop) begin
				top_q <= top_m1;
			end else if (upd.push) begin
				stack_q[top_q[ID_W-1:0]] <= upd.id;
				top_q <= top_q + TOP_W'(1);
			end
			if (upd.cnt_we) begin
				cnt_q[upd.id] <= upd.cnt;
			end
			if (upd.flag_we) begin
				alloc_q[upd.id] <= upd.flag;
			end
		end
	end

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(NUM_QUEUES))
		else $error("free stack top out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		upd.pop |-> top_q != '0)
		else $error("pop from empty free stack");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		upd.push |-> top_q != TOP_W'(NUM_QUEUES))
		else $error("push onto full free stack");

	// ids off the allocated set always carry a zero count
	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!alloc_q[rd_qid] |-> cnt_q[rd_qid] == '0)
		else $error("unallocated id holds a nonzero refcount");

	a_pop_marks: assert property (@(posedge clk) disable iff (!arst_n)
		upd.pop |=> alloc_q[$past(upd.id)])
		else $error("popped id not marked allocated");

endmodule

`default_nettype wire

// ===== src/qida_exec.sv =====
// Command evaluation: checks, result fields and the state change for one command.
// Depends on qida_pkg.
`default_nettype none

module qida_exec
	import qida_pkg::*;
#(
	parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
	input  wire in_t   item,
	input  wire addr_t base,
	input  wire rd_t   rd,
	output out_t       res,
	output upd_t       upd
);

	logic dev_bad;
	logic qid_bad;

	assign dev_bad = {1'b0, item.device_id} >= (DEV_W + 1)'(NUM_DEVICES);
	assign qid_bad = {1'b0, item.queue_id} >= (ID_W + 1)'(NUM_QUEUES);

	always_comb begin
		res = '{status: ST_OK, result_id: item.queue_id, reference_count: '0,
			free_count: '0, queue_address: '0};
		upd = '0;
		upd.id = item.queue_id;

		if (item.command > CMD_QUERY) begin
			res.status = ST_BAD_COMMAND;
		end else if (dev_bad) begin
			res.status = ST_BAD_DEVICE;
		end else if (item.command == CMD_ALLOC) begin
			if (rd.top == '0) begin
				res.status    = ST_NONE_FREE;
				res.result_id = '0;
			end else begin
				upd.pop     = 1'b1;
				upd.id      = rd.pop_id;
				upd.flag_we = 1'b1;
				upd.flag    = 1'b1;
				// a free id always carries a zero count
				res.result_id     = rd.pop_id;
				res.free_count    = rd.top - TOP_W'(1);
				res.queue_address = addr_of(base, rd.pop_id);
			end
		end else if (qid_bad) begin
			res.status     = ST_BAD_ID;
			res.free_count = rd.top;
		end else begin
			res.reference_count = rd.cnt;
			res.free_count      = rd.top;
			res.queue_address   = addr_of(base, item.queue_id);
			if (item.command != CMD_QUERY && !rd.alloc) begin
				res.status = ST_NOT_ALLOC;
			end else begin
				case (item.command)
					CMD_FREE: begin
						if (rd.cnt != '0) begin
							res.status = ST_REFERENCED;
						end else if (rd.top < TOP_W'(NUM_QUEUES)) begin
							upd.push       = 1'b1;
							upd.flag_we    = 1'b1;
							upd.flag       = 1'b0;
							res.free_count = rd.top + TOP_W'(1);
						end
					end
					CMD_ADD: begin
						if (rd.cnt == CNT_MAX) begin
							res.status = ST_OVERFLOW;
						end else begin
							upd.cnt_we          = 1'b1;
							upd.cnt             = rd.cnt + CNT_W'(1);
							res.reference_count = upd.cnt;
						end
					end
					CMD_DROP: begin
						if (rd.cnt == '0) begin
							res.status = ST_UNDERFLOW;
						end else begin
							upd.cnt_we          = 1'b1;
							upd.cnt             = rd.cnt - CNT_W'(1);
							res.reference_count = upd.cnt;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for queue_id_allocator_with_refcount: random and directed commands,
// checked against a cycle-free model of the id stack and reference counts.
// Depends on qida_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top
	import qida_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;

	// Model of the allocator plus the list of results still owed by the block.
	class qid_scoreboard;
		id_t         free_ids[NUM_QUEUES];
		int unsigned stack_top;
		cnt_t        refs[NUM_QUEUES];
		bit          in_use[NUM_QUEUES];
		addr_t       base;
		out_t        owed[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned status_seen[16];

		function new();
			for (int i = 0; i < NUM_QUEUES; i++) begin
				free_ids[i] = id_t'(NUM_QUEUES - 1 - i);
				refs[i] = '0;
				in_use[i] = 1'b0;
			end
			stack_top = NUM_QUEUES;
			base = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_base(addr_t b);
			base = b;
		endfunction

		function addr_t addr_for(id_t id);
			return base + addr_t'(id) * addr_t'(QUEUE_DEPTH * SLOT_BYTES);
		endfunction

		function void note_command(in_t c);
			out_t r;
			id_t  id;
			r = '0;
			r.result_id = c.queue_id;
			if (c.command > CMD_QUERY) begin
				r.status = ST_BAD_COMMAND;
			end else if (c.device_id >= NUM_DEVICES_DEF) begin
				r.status = ST_BAD_DEVICE;
			end else if (c.command == CMD_ALLOC) begin
				if (stack_top == 0) begin
					r.status = ST_NONE_FREE;
					r.result_id = '0;
				end else begin
					stack_top--;
					id = free_ids[stack_top];
					in_use[id] = 1'b1;
					r.status = ST_OK;
					r.result_id = id;
					r.reference_count = refs[id];
					r.free_count = top_t'(stack_top);
					r.queue_address = addr_for(id);
				end
			end else begin
				id = c.queue_id;
				r.status = ST_OK;
				if (c.command != CMD_QUERY && !in_use[id]) begin
					r.status = ST_NOT_ALLOC;
				end else if (c.command == CMD_FREE) begin
					if (refs[id] != 0) begin
						r.status = ST_REFERENCED;
					end else begin
						free_ids[stack_top] = id;
						stack_top++;
						in_use[id] = 1'b0;
					end
				end else if (c.command == CMD_ADD) begin
					if (refs[id] == CNT_MAX)
						r.status = ST_OVERFLOW;
					else
						refs[id] = refs[id] + 1'b1;
				end else if (c.command == CMD_DROP) begin
					if (refs[id] == 0)
						r.status = ST_UNDERFLOW;
					else
						refs[id] = refs[id] - 1'b1;
				end
				r.reference_count = refs[id];
				r.free_count = top_t'(stack_top);
				r.queue_address = addr_for(id);
			end
			status_seen[r.status]++;
			owed.push_back(r);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (owed.size() == 0) begin
				$error("result with nothing outstanding: status %0d id %0d",
					got.status, got.result_id);
				errors++;
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.result_id !== want.result_id) begin
				$error("result_id mismatch: expected %0d, got %0d",
					want.result_id, got.result_id);
				errors++;
			end
			if (got.reference_count !== want.reference_count) begin
				$error("reference_count mismatch: expected %0d, got %0d",
					want.reference_count, got.reference_count);
				errors++;
			end
			if (got.free_count !== want.free_count) begin
				$error("free_count mismatch: expected %0d, got %0d",
					want.free_count, got.free_count);
				errors++;
			end
			if (got.queue_address !== want.queue_address) begin
				$error("queue_address mismatch: expected %h, got %h",
					want.queue_address, got.queue_address);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction

		// random allocated id, or any id when none is allocated
		function id_t pick_in_use();
			id_t held[$];
			for (int i = 0; i < NUM_QUEUES; i++)
				if (in_use[i])
					held.push_back(id_t'(i));
			if (held.size() == 0)
				return id_t'($urandom);
			return held[$urandom_range(held.size() - 1)];
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	in_t   in_data = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	out_t  out_data;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	addr_t cfg_data = '0;

	qid_scoreboard sb = new();
	int unsigned   in_idle_pct = 8;
	int unsigned   out_idle_pct = 8;
	int unsigned   cycle_count = 0;
	int unsigned   sent = 0;
	int unsigned   base_writes = 0;

	queue_id_allocator_with_refcount dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// called at a falling edge, returns at a falling edge
	task automatic send(input logic [CMD_W-1:0] op, input logic [DEV_W-1:0] dev,
		input id_t qid);
		in_t c;
		c.command = op;
		c.device_id = dev;
		c.queue_id = qid;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_command(c);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_base(input addr_t v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_base(v);
		base_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_cmd();
		int unsigned r;
		id_t         q;
		r = $urandom_range(99);
		q = sb.pick_in_use();
		if (r < 28)
			send(CMD_ALLOC, '0, id_t'($urandom));
		else if (r < 46)
			send(CMD_FREE, '0, q);
		else if (r < 58)
			send(CMD_ADD, '0, q);
		else if (r < 74)
			send(CMD_DROP, '0, q);
		else if (r < 84)
			send(CMD_QUERY, '0, id_t'($urandom));
		else if (r < 93)
			send(CMD_W'($urandom_range(int'(CMD_QUERY))), '0, id_t'($urandom));
		else if (r < 97)
			send(CMD_W'($urandom_range(7, int'(CMD_QUERY) + 1)), DEV_W'($urandom),
				id_t'($urandom));
		else
			send(CMD_W'($urandom_range(int'(CMD_QUERY))),
				DEV_W'($urandom_range(3, NUM_DEVICES_DEF)), id_t'($urandom));
	endtask

	// allocate, push one held id's count to the top, one past it, down and past zero, then free it
	task automatic saturate_refs();
		id_t id;
		send(CMD_ALLOC, '0, '0);
		id = sb.pick_in_use();
		while (sb.refs[id] != CNT_MAX)
			send(CMD_ADD, '0, id);
		send(CMD_ADD, '0, id);
		while (sb.refs[id] != 0)
			send(CMD_DROP, '0, id);
		send(CMD_DROP, '0, id);
		send(CMD_FREE, '0, id);
	endtask

	// empty the stack, allocate past empty, then try to free every id
	task automatic exhaust_stack();
		while (sb.stack_top != 0)
			send(CMD_ALLOC, '0, id_t'($urandom));
		send(CMD_ALLOC, '0, '0);
		send(CMD_ALLOC, '0, '1);
		for (int i = 0; i < NUM_QUEUES; i++)
			send(CMD_FREE, '0, id_t'(i));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_base(addr_t'({$urandom, $urandom}));

		// directed: lifecycle of two ids, referenced, underflow, not-allocated, bad command and bad device
		send(CMD_ALLOC, '0, '0);
		send(CMD_ALLOC, '0, '1);
		send(CMD_QUERY, '0, 5'd1);
		send(CMD_ADD, '0, 5'd1);
		send(CMD_ADD, '0, 5'd1);
		send(CMD_DROP, '0, 5'd1);
		send(CMD_FREE, '0, 5'd1);
		send(CMD_DROP, '0, 5'd1);
		send(CMD_DROP, '0, 5'd1);
		send(CMD_FREE, '0, 5'd1);
		send(CMD_FREE, '0, 5'd1);
		send(CMD_ADD, '0, 5'd1);
		send(CMD_DROP, '0, '1);
		send(CMD_QUERY, '0, '1);
		send(CMD_ALLOC, '0, '0);
		for (int op = int'(CMD_QUERY) + 1; op < 8; op++)
			send(CMD_W'(op), '0, '1);
		for (int dev = NUM_DEVICES_DEF; dev < 4; dev++)
			send(CMD_ALLOC, DEV_W'(dev), id_t'(dev));
		drain();

		write_base('1);
		for (int i = 0; i < 350; i++)
			random_cmd();
		exhaust_stack();
		drain();

		// long stretch with both sides always ready
		write_base('0);
		in_idle_pct = 0;
		out_idle_pct = 0;
		saturate_refs();
		for (int i = 0; i < 350; i++)
			random_cmd();
		drain();

		in_idle_pct = 8;
		out_idle_pct = 8;
		write_base(addr_t'({$urandom, $urandom}));
		for (int i = 0; i < 350; i++)
			random_cmd();
		exhaust_stack();
		for (int i = 0; i < 100; i++)
			random_cmd();
		drain();

		repeat (10) @(negedge clk);
		$display("Sent %0d commands over %0d base settings, %0d results checked.",
			sent, base_writes, sb.checked);
		$display("Status mix: ok %0d, none free %0d, referenced %0d, not allocated %0d,",
			sb.status_seen[ST_OK], sb.status_seen[ST_NONE_FREE],
			sb.status_seen[ST_REFERENCED], sb.status_seen[ST_NOT_ALLOC],
			" over %0d, under %0d, bad device %0d, bad command %0d",
			sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_UNDERFLOW],
			sb.status_seen[ST_BAD_DEVICE], sb.status_seen[ST_BAD_COMMAND]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/qida_pkg.sv
src/qida_bank.sv
src/qida_exec.sv
src/queue_id_allocator_with_refcount.sv
test/tb_top.sv
